[src/tct_pkg.sv]
package tct_pkg;

    // event kinds
    localparam logic [1:0] MODE_DOWN = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_SCALE_X = 2'd0;
    localparam logic [1:0] REG_SCALE_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS  = 2'd2;

    localparam logic [15:0] SCALE_RESET  = 16'd4096;
    localparam logic [32:0] RADIUS_RESET = 33'd10000;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic [31:0] touch_ms;
    } t_entry;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [4:0] active_count;
        t_entry     entry;
    } t_result;

    // control from sequencer to the distance unit
    typedef struct packed {
        logic       start;  // new search: reload best with the radius
        logic       vld;    // head cell holds a live contact
        logic [3:0] slot;   // slot index of the head cell
    } t_near_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_APPLY,
        S_OUT
    } t_state;

endpackage

[src/tct_if.sv]
interface tct_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] place_x;
    logic [11:0] place_y;
    logic [11:0] seek_x;
    logic [11:0] seek_y;
    logic [31:0] timestamp_ms;

    modport source (
        output valid, mode, place_x, place_y, seek_x, seek_y, timestamp_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, place_x, place_y, seek_x, seek_y, timestamp_ms,
        output ready
    );
endinterface

interface tct_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [4:0]  active_count;
    logic [15:0] entry_pos_x;
    logic [15:0] entry_pos_y;
    logic [15:0] entry_hit_x;
    logic [15:0] entry_hit_y;
    logic [31:0] entry_hit_time;

    modport source (
        output valid, status, slot, active_count, entry_pos_x, entry_pos_y,
               entry_hit_x, entry_hit_y, entry_hit_time,
        input  ready
    );
    modport sink (
        input  valid, status, slot, active_count, entry_pos_x, entry_pos_y,
               entry_hit_x, entry_hit_y, entry_hit_time,
        output ready
    );
endinterface

[src/touch_contact_tracker_top.sv]
// Channel  Dir  Handshake      Word
// i_evt    in   valid/ready    mode, place_x/y, seek_x/y, timestamp_ms
// o_res    out  valid/ready    status, slot, active_count, entry_*
// apb      in   psel/penable   scale_x @0x00, scale_y @0x08, match_radius_sq @0x10
//
// One event at a time. Contacts sit in a ring of MAX_CONTACTS cells that
// rotates one slot per cycle in the search and update passes; all reads and
// writes happen at the head cell. Down: accept, N-step write pass, result.
// Move/up: accept, N-step search pass, a drain state for the distance
// pipeline, N-step update pass, result. Full/empty/unknown: accept, result.
// The ring rotations set the rate. Reset clears the count and registers;
// cell contents are don't-care until written. A stalled result holds the
// block in its output state; no new event is taken until it leaves.
module touch_contact_tracker_top #(
    parameter int MAX_CONTACTS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tct_evt_if.sink     i_evt,
    tct_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import tct_pkg::*;

    localparam logic [4:0] MAX_C     = 5'(MAX_CONTACTS);
    localparam logic [3:0] LAST_STEP = 4'(MAX_CONTACTS - 1);

    // (raw * scale + 2048) >> 12; the 28-bit sum never exceeds 16 result
    // bits for a 12-bit raw value, so no saturation is needed
    function automatic logic [15:0] scale_pos(input logic [11:0] raw,
                                              input logic [15:0] scale);
        logic [27:0] prod;
        prod = ({16'd0, raw} * {12'd0, scale}) + 28'd2048;
        return prod[27:12];
    endfunction

    // configuration
    logic [15:0] r_scale_x;
    logic [15:0] r_scale_y;
    logic [32:0] r_radius;

    // sequencer
    t_state      r_state, n_state;
    logic [1:0]  r_mode, n_mode;
    logic [3:0]  r_step, n_step;
    logic [4:0]  r_count, n_count;
    logic [3:0]  r_target, n_target;
    logic [15:0] r_px, n_px;
    logic [15:0] r_py, n_py;
    logic [15:0] r_sx, n_sx;
    logic [15:0] r_sy, n_sy;
    logic [31:0] r_time, n_time;
    t_entry      r_last, n_last;
    t_result     r_res, n_res;

    logic        w_shift;
    t_entry      w_tail;
    t_entry      w_mod;
    t_entry      w_head;
    logic [3:0]  w_target;
    logic [3:0]  w_best;
    t_near_ctrl  w_near;
    logic        w_wr;

    t_entry      w_cell_out [MAX_CONTACTS];

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
            r_radius  <= RADIUS_RESET;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_SCALE_X: r_scale_x <= pwdata[15:0];
                REG_SCALE_Y: r_scale_y <= pwdata[15:0];
                REG_RADIUS:  r_radius  <= pwdata[32:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_SCALE_X: prdata = {48'd0, r_scale_x};
            REG_SCALE_Y: prdata = {48'd0, r_scale_y};
            REG_RADIUS:  prdata = {31'd0, r_radius};
            default:     prdata = '0;
        endcase
    end

    // ---------------- contact ring ----------------
    // cell k takes cell k+1; the last cell takes the (possibly edited) head
    genvar g;
    generate
        for (g = 0; g < MAX_CONTACTS; g++) begin : g_cell
            t_entry w_in;
            if (g == MAX_CONTACTS - 1) begin : g_tail
                assign w_in = w_tail;
            end else begin : g_link
                assign w_in = w_cell_out[g + 1];
            end
            tct_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (w_in),
                .o_data  (w_cell_out[g])
            );
        end
    endgenerate

    assign w_head = w_cell_out[0];

    tct_nearest u_nearest (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_near),
        .i_pos_x     (w_head.pos_x),
        .i_pos_y     (w_head.pos_y),
        .i_seek_x    (r_sx),
        .i_seek_y    (r_sy),
        .i_radius    (r_radius),
        .o_best_slot (w_best)
    );

    // down writes at the old count; move/up at the search winner
    assign w_target = (r_mode == MODE_DOWN) ? r_target : w_best;

    // edited head entry for the update pass
    always_comb begin
        w_mod = w_head;
        case (r_mode)
            MODE_DOWN: begin
                w_mod.pos_x    = r_px;
                w_mod.pos_y    = r_py;
                w_mod.hit_x    = r_px;
                w_mod.hit_y    = r_py;
                w_mod.touch_ms = r_time;
            end
            MODE_MOVE: begin
                w_mod.pos_x = r_px;
                w_mod.pos_y = r_py;
            end
            default: w_mod = r_last;  // up: last entry fills the hole
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_target <= n_target;
        r_px     <= n_px;
        r_py     <= n_py;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_time   <= n_time;
        r_last   <= n_last;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_step   = r_step;
        n_count  = r_count;
        n_target = r_target;
        n_px     = r_px;
        n_py     = r_py;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_time   = r_time;
        n_last   = r_last;
        n_res    = r_res;
        w_shift  = 1'b0;
        w_tail   = w_head;
        w_near   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_evt.valid) begin
                    n_mode   = i_evt.mode;
                    n_px     = scale_pos(i_evt.place_x, r_scale_x);
                    n_py     = scale_pos(i_evt.place_y, r_scale_y);
                    n_sx     = scale_pos(i_evt.seek_x, r_scale_x);
                    n_sy     = scale_pos(i_evt.seek_y, r_scale_y);
                    n_time   = i_evt.timestamp_ms;
                    n_step   = '0;
                    n_target = r_count[3:0];
                    n_res    = '0;
                    n_res.active_count = r_count;
                    case (i_evt.mode) inside
                        MODE_DOWN: begin
                            if (r_count >= MAX_C) begin
                                n_res.status = ST_FULL;
                                n_state      = S_OUT;
                            end else begin
                                n_state = S_APPLY;
                            end
                        end
                        MODE_MOVE, MODE_UP: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                                n_state      = S_OUT;
                            end else begin
                                w_near.start = 1'b1;
                                n_state      = S_SEARCH;
                            end
                        end
                        default: n_state = S_OUT;  // unknown kind: no change
                    endcase
                end
            end

            S_SEARCH: begin
                w_shift     = 1'b1;
                w_near.vld  = ({1'b0, r_step} < r_count);
                w_near.slot = r_step;
                if ({1'b0, r_step} == (r_count - 5'd1)) begin
                    n_last = w_head;
                end
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end

            // lets the last distance reach the compare stage
            S_DRAIN: n_state = S_APPLY;

            S_APPLY: begin
                w_shift = 1'b1;
                if (r_step == w_target) begin
                    w_tail       = w_mod;
                    n_res.status = ST_DONE;
                    n_res.slot   = w_target;
                    n_res.entry  = (r_mode == MODE_UP) ? w_head : w_mod;
                end
                if (r_step == LAST_STEP) begin
                    n_step = '0;
                    case (r_mode)
                        MODE_DOWN: n_count = r_count + 5'd1;
                        MODE_UP:   n_count = r_count - 5'd1;
                        default:   n_count = r_count;
                    endcase
                    n_res.active_count = n_count;
                    n_state            = S_OUT;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end

            S_OUT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- ports ----------------
    assign i_evt.ready = (r_state == S_IDLE);

    assign o_res.valid          = (r_state == S_OUT);
    assign o_res.status         = r_res.status;
    assign o_res.slot           = r_res.slot;
    assign o_res.active_count   = r_res.active_count;
    assign o_res.entry_pos_x    = r_res.entry.pos_x;
    assign o_res.entry_pos_y    = r_res.entry.pos_y;
    assign o_res.entry_hit_x    = r_res.entry.hit_x;
    assign o_res.entry_hit_y    = r_res.entry.hit_y;
    assign o_res.entry_hit_time = r_res.entry.touch_ms;

endmodule

[src/tct_cell.sv]
module tct_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  tct_pkg::t_entry i_data,
    output tct_pkg::t_entry o_data
);
    import tct_pkg::*;

    t_entry r_entry;

    // one contact; takes its neighbor's contact on every ring step
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_data;
        end
    end

    assign o_data = r_entry;

endmodule

[src/tct_nearest.sv]
module tct_nearest (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tct_pkg::t_near_ctrl i_ctrl,
    input  logic [15:0]         i_pos_x,
    input  logic [15:0]         i_pos_y,
    input  logic [15:0]         i_seek_x,
    input  logic [15:0]         i_seek_y,
    input  logic [32:0]         i_radius,
    output logic [3:0]          o_best_slot
);
    import tct_pkg::*;

    logic [15:0] w_ax;
    logic [15:0] w_ay;
    logic [32:0] w_dist;

    logic        r_vld;
    logic [3:0]  r_slot;
    logic [31:0] r_sq_x;
    logic [31:0] r_sq_y;
    logic [32:0] r_best;
    logic [3:0]  r_best_slot;

    // absolute differences, so the squares stay unsigned 16x16
    assign w_ax = (i_pos_x >= i_seek_x) ? (i_pos_x - i_seek_x) : (i_seek_x - i_pos_x);
    assign w_ay = (i_pos_y >= i_seek_y) ? (i_pos_y - i_seek_y) : (i_seek_y - i_pos_y);
    assign w_dist = {1'b0, r_sq_x} + {1'b0, r_sq_y};

    // stage 1: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_ctrl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= i_ctrl.slot;
        r_sq_x <= w_ax * w_ax;
        r_sq_y <= w_ay * w_ay;
    end

    // stage 2: sum and strict compare; slots arrive in ascending order,
    // so equal distances keep the lower slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_best      <= i_radius;
            r_best_slot <= '0;
        end else if (r_vld && (w_dist < r_best)) begin
            r_best      <= w_dist;
            r_best_slot <= r_slot;
        end
    end

    assign o_best_slot = r_best_slot;

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tct_pkg::*;

    localparam int N_CONTACTS = 11;
    // idle cycles with no word moving on either channel before giving up
    localparam int STALL_LIMIT = 5000;
    // the one mode value the block has no name for; it must pass through untouched
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [32:0] RADIUS_MAX = 33'h1_FFFF_FFFE;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] place_x;
        logic [11:0] place_y;
        logic [11:0] seek_x;
        logic [11:0] seek_y;
        logic [31:0] timestamp_ms;
    } t_touch_evt;

    // Contact table mirror: tracks scales, radius and the live contacts, and
    // turns each accepted event into the result word the block must return.
    class contact_table_sb;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [32:0] radius_sq;
        int unsigned live_count;
        t_entry      contacts[N_CONTACTS];
        t_result     expected_results[$];
        int unsigned errors;

        function new();
            scale_x    = SCALE_RESET;
            scale_y    = SCALE_RESET;
            radius_sq  = RADIUS_RESET;
            live_count = 0;
            errors     = 0;
            foreach (contacts[i]) contacts[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_SCALE_X: scale_x = val[15:0];
                REG_SCALE_Y: scale_y = val[15:0];
                REG_RADIUS:  radius_sq = val[32:0];
                default: ;
            endcase
        endfunction

        // Q4.12 scale, round half up, clamp to 16 bits
        static function logic [15:0] scale_coord(logic [11:0] raw, logic [15:0] k);
            logic [28:0] prod;
            prod = 29'(raw) * 29'(k) + 29'd2048;
            return (prod[28:12] > 17'd65535) ? 16'hFFFF : prod[27:12];
        endfunction

        // strict less-than keeps the lowest slot on ties; slot 0 if none in radius
        function int unsigned nearest_contact(logic [15:0] sx, logic [15:0] sy);
            logic [33:0] best;
            logic [33:0] sq_dist;
            logic [15:0] dx;
            logic [15:0] dy;
            int unsigned pick;
            best = 34'(radius_sq);
            pick = 0;
            for (int unsigned i = 0; i < live_count; i++) begin
                dx = (contacts[i].pos_x >= sx) ? contacts[i].pos_x - sx : sx - contacts[i].pos_x;
                dy = (contacts[i].pos_y >= sy) ? contacts[i].pos_y - sy : sy - contacts[i].pos_y;
                sq_dist = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
                if (sq_dist < best) begin
                    best = sq_dist;
                    pick = i;
                end
            end
            return pick;
        endfunction

        function void note_event(t_touch_evt e);
            t_result     want;
            int unsigned i;
            logic [15:0] px;
            logic [15:0] py;
            want = '0;
            px = scale_coord(e.place_x, scale_x);
            py = scale_coord(e.place_y, scale_y);
            case (e.mode)
                MODE_DOWN: begin
                    if (live_count >= N_CONTACTS) begin
                        want.status = ST_FULL;
                    end else begin
                        i = live_count;
                        contacts[i] = '{pos_x: px, pos_y: py, hit_x: px, hit_y: py,
                                        touch_ms: e.timestamp_ms};
                        want.slot  = 4'(i);
                        want.entry = contacts[i];
                        live_count++;
                    end
                end
                MODE_MOVE, MODE_UP: begin
                    if (live_count == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        i = nearest_contact(scale_coord(e.seek_x, scale_x),
                                            scale_coord(e.seek_y, scale_y));
                        want.slot = 4'(i);
                        if (e.mode == MODE_MOVE) begin
                            contacts[i].pos_x = px;
                            contacts[i].pos_y = py;
                            want.entry = contacts[i];
                        end else begin
                            want.entry = contacts[i];
                            live_count--;
                            contacts[i] = contacts[live_count];
                        end
                    end
                end
                default: ;
            endcase
            want.active_count = 5'(live_count);
            expected_results.push_back(want);
        endfunction

        function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, actual slot %0d status %0d",
                         $time, got.slot, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            bad  = 1'b0;
            bad |= field_differs("status", 32'(want.status), 32'(got.status));
            bad |= field_differs("slot", 32'(want.slot), 32'(got.slot));
            bad |= field_differs("active_count", 32'(want.active_count),
                                 32'(got.active_count));
            bad |= field_differs("entry_pos_x", 32'(want.entry.pos_x), 32'(got.entry.pos_x));
            bad |= field_differs("entry_pos_y", 32'(want.entry.pos_y), 32'(got.entry.pos_y));
            bad |= field_differs("entry_hit_x", 32'(want.entry.hit_x), 32'(got.entry.hit_x));
            bad |= field_differs("entry_hit_y", 32'(want.entry.hit_y), 32'(got.entry.hit_y));
            bad |= field_differs("entry_hit_time", want.entry.touch_ms, got.entry.touch_ms);
            if (bad) errors++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    tct_evt_if evt ();
    tct_res_if res ();

    touch_contact_tracker_top #(
        .MAX_CONTACTS(N_CONTACTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    contact_table_sb sb = new();

    t_touch_evt directed_q[$];
    // random mix leans toward adding contacts while set, toward removing otherwise
    bit grow = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic t_touch_evt mk_event(logic [1:0] m, logic [11:0] px, logic [11:0] py,
                                            logic [11:0] sx, logic [11:0] sy,
                                            logic [31:0] t);
        t_touch_evt e;
        e = '{mode: m, place_x: px, place_y: py, seek_x: sx, seek_y: sy, timestamp_ms: t};
        return e;
    endfunction

    // raw coordinate that scales back to roughly pos, jittered by up to +/- jit
    function automatic logic [11:0] raw_near(logic [15:0] pos, logic [15:0] k, int jit);
        int v;
        if (k == 16'd0) return 12'($urandom_range(0, 4095));
        v = (int'(pos) * 4096 + int'(k) / 2) / int'(k);
        v = v + int'($urandom_range(0, 2 * jit)) - jit;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    // Mostly well-formed traffic aimed at live contacts; the rest is raw noise,
    // unknown modes and events on a full or empty table.
    function automatic t_touch_evt random_event();
        t_touch_evt  e;
        int unsigned r;
        int unsigned k;
        e.place_x      = 12'($urandom_range(0, 4095));
        e.place_y      = 12'($urandom_range(0, 4095));
        e.seek_x       = 12'($urandom_range(0, 4095));
        e.seek_y       = 12'($urandom_range(0, 4095));
        e.timestamp_ms = $urandom();
        if ($urandom_range(0, 29) == 0) grow = !grow;
        r = $urandom_range(0, 99);
        if (r < 3)                      e.mode = MODE_UNUSED;
        else if (r < (grow ? 63 : 18))  e.mode = MODE_DOWN;
        else if (r < (grow ? 88 : 53))  e.mode = MODE_MOVE;
        else                            e.mode = MODE_UP;
        if (sb.live_count > 0) begin
            k = $urandom_range(0, sb.live_count - 1);
            if ($urandom_range(0, 3) != 0) begin
                e.seek_x = raw_near(sb.contacts[k].pos_x, sb.scale_x, 3);
                e.seek_y = raw_near(sb.contacts[k].pos_y, sb.scale_y, 3);
            end
            // stack a new contact on an old one now and then so ties come up
            if (e.mode == MODE_DOWN && $urandom_range(0, 4) == 0) begin
                e.place_x = raw_near(sb.contacts[k].pos_x, sb.scale_x, 0);
                e.place_y = raw_near(sb.contacts[k].pos_y, sb.scale_y, 0);
            end
        end
        return e;
    endfunction

    task automatic build_directed();
        // events on the empty table, including the unnamed mode
        directed_q.push_back(mk_event(MODE_MOVE, 10, 20, 30, 40, 5));
        directed_q.push_back(mk_event(MODE_UP, 10, 20, 30, 40, 6));
        directed_q.push_back(mk_event(MODE_UNUSED, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
        // corners, time extremes, and two contacts on one spot
        directed_q.push_back(mk_event(MODE_DOWN, 0, 0, 0, 0, 0));
        directed_q.push_back(mk_event(MODE_DOWN, 4095, 4095, 0, 0, 32'hFFFF_FFFF));
        directed_q.push_back(mk_event(MODE_DOWN, 4095, 4095, 4095, 4095, 1));
        // equal distance: lower slot wins
        directed_q.push_back(mk_event(MODE_MOVE, 100, 200, 4095, 4095, 2));
        // nothing inside the radius: falls back to slot 0
        directed_q.push_back(mk_event(MODE_MOVE, 5, 5, 2000, 2000, 3));
        // remove the last entry itself
        directed_q.push_back(mk_event(MODE_UP, 0, 0, 4095, 4095, 4));
        repeat (N_CONTACTS - 2) begin
            directed_q.push_back(mk_event(MODE_DOWN, 12'($urandom), 12'($urandom),
                                          12'($urandom), 12'($urandom), $urandom()));
        end
        // full table
        directed_q.push_back(mk_event(MODE_DOWN, 300, 300, 0, 0, 7));
        directed_q.push_back(mk_event(MODE_UNUSED, 0, 0, 0, 0, 8));
        // remove slot 0 so the last entry moves into it
        directed_q.push_back(mk_event(MODE_UP, 0, 0, 5, 5, 9));
        directed_q.push_back(mk_event(MODE_MOVE, 12'($urandom), 12'($urandom),
                                      12'($urandom), 12'($urandom), $urandom()));
    endtask

    // always waits for a clock edge first, so valid never toggles within a step
    task automatic wait_results_drained();
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    // three back-to-back APB writes; psel stays up between them
    task automatic write_config(logic [15:0] sx, logic [15:0] sy, logic [32:0] rad);
        logic [63:0] vals[3];
        logic [1:0]  idx[3];
        vals = '{64'(sx), 64'(sy), 64'(rad)};
        idx  = '{REG_SCALE_X, REG_SCALE_Y, REG_RADIUS};
        for (int n = 0; n < 3; n++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[n], 3'b000};
            pwdata  <= vals[n];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            sb.set_reg(idx[n], vals[n]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Plays the directed queue first, then n_random generated events, in bursts.
    // Each event is generated only after the previous one was accepted, so the
    // generator sees the table as the block will.
    task automatic drive_events(int n_random);
        t_touch_evt e;
        int         total;
        int         burst_left;
        total      = directed_q.size() + n_random;
        burst_left = $urandom_range(1, 12);
        for (int k = 0; k < total; k++) begin
            e = (directed_q.size() != 0) ? directed_q.pop_front() : random_event();
            evt.valid        <= 1'b1;
            evt.mode         <= e.mode;
            evt.place_x      <= e.place_x;
            evt.place_y      <= e.place_y;
            evt.seek_x       <= e.seek_x;
            evt.seek_y       <= e.seek_y;
            evt.timestamp_ms <= e.timestamp_ms;
            do @(posedge i_clk); while (!evt.ready);
            sb.note_event(e);
            burst_left--;
            if (k == total - 1) begin
                evt.valid <= 1'b0;
            end else if (burst_left == 0) begin
                evt.valid <= 1'b0;
                // occasionally hold off until the block has nothing in flight
                if ($urandom_range(0, 19) == 0) wait_results_drained();
                else repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: ready follows a duty cycle drawn anew for every segment,
    // including full-rate stretches; every accepted word goes to the checker.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int      seg_left;
        int      duty;
        t_result got;
        seg_left  = 0;
        duty      = 100;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                got.status         = res.status;
                got.slot           = res.slot;
                got.active_count   = res.active_count;
                got.entry.pos_x    = res.entry_pos_x;
                got.entry.pos_y    = res.entry_pos_y;
                got.entry.hit_x    = res.entry_hit_x;
                got.entry.hit_y    = res.entry_hit_y;
                got.entry.touch_ms = res.entry_hit_time;
                sb.check_result(got);
            end
            if (seg_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    duty = 100;
                    2:       duty = 75;
                    3:       duty = 40;
                    default: duty = 10;
                endcase
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            res.ready <= ($urandom_range(0, 99) < duty);
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on either channel for too long.
    // ---------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((evt.valid === 1'b1 && evt.ready === 1'b1) ||
                (res.valid === 1'b1 && res.ready === 1'b1)) quiet = 0;
            else quiet++;
        end
        $display("touch_contact_tracker_top verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence. The contact table is never cleared between phases, so
    // contacts placed under one scale get searched under the next one.
    // ---------------------------------------------------------------------
    initial begin : main_seq
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        evt.valid        <= 1'b0;
        evt.mode         <= MODE_DOWN;
        evt.place_x      <= '0;
        evt.place_y      <= '0;
        evt.seek_x       <= '0;
        evt.seek_y       <= '0;
        evt.timestamp_ms <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass under reset values (scale 1.0, radius 10000)
        build_directed();
        drive_events(0);

        // zero x scale collapses x, radius 0 forces the slot 0 fallback
        wait_results_drained();
        write_config(16'd0, 16'hFFFF, 33'd0);
        drive_events(95);

        // max x scale, zero y scale, radius at RADIUS_MAX, above any squared distance: every search hits
        wait_results_drained();
        write_config(16'hFFFF, 16'd0, RADIUS_MAX);
        drive_events(95);

        // random scales around unity, radius either tight or anywhere
        wait_results_drained();
        write_config(16'($urandom_range(1024, 16384)), 16'($urandom_range(1024, 16384)),
                     ($urandom_range(0, 1) != 0) ? 33'($urandom_range(0, 200000))
                                                 : {1'($urandom_range(0, 1)), $urandom()});
        drive_events(95);

        // back to reset values
        wait_results_drained();
        write_config(SCALE_RESET, SCALE_RESET, RADIUS_RESET);
        drive_events(95);

        wait_results_drained();
        // let a late or extra word show up before judging
        repeat (2 * N_CONTACTS + 16) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("touch_contact_tracker_top verification clean");
        end else begin
            $display("touch_contact_tracker_top verification failed");
        end
        $finish;
    end

endmodule
